@@ rtl/kpt_pkg.sv @@
package kpt_pkg;

  // default table depth
  localparam int MAX_PAIRS_DEF = 64;

  // character code that no stored pair may use
  localparam logic [7:0] KEY_RESERVED = 8'd255;

  // operation codes
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  // input word
  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        first_char;
    logic [7:0]        second_char;
    logic signed [7:0] offset_in;
  } kpt_in_t;

  // result word
  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic signed [7:0] offset_out;
    logic [5:0]        pair_index;
    logic [6:0]        pair_count;
  } kpt_out_t;

  // one table entry
  typedef struct packed {
    logic [7:0]        first_char;
    logic [7:0]        second_char;
    logic signed [7:0] offset;
  } kpt_entry_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic clear;
    logic reject;
    logic scan;
    logic hit;
    logic upd;
    logic append;
    logic full;
    logic shift;
    logic dec;
    logic load;
  } kpt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_lookup;
    logic is_write;
    logic is_clear;
    logic rsv;
    logic off_zero;
    logic hit;
    logic miss;
    logic full;
    logic shift_done;
  } kpt_sts_t;

endpackage

@@ rtl/kpt_datapath.sv @@
module kpt_datapath #(
  parameter int MAX_PAIRS = kpt_pkg::MAX_PAIRS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kpt_pkg::kpt_cmd_t cmd,
  output kpt_pkg::kpt_sts_t sts,
  input  kpt_pkg::kpt_in_t  in_data,
  output kpt_pkg::kpt_out_t out_data
);
  import kpt_pkg::*;

  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int IW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAIRS);

  kpt_entry_t        mem [MAX_PAIRS];
  kpt_entry_t        rdata_r;
  kpt_in_t           item_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]     wp_r, wp_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              found_r, found_nxt;
  logic signed [7:0] old_r, old_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  kpt_out_t          out_r;

  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  kpt_entry_t        wr_data;
  logic [CW-1:0]     hit_pos;
  logic              more;
  logic              key_match;

  // scan pointer runs one ahead of the entry held in the read register
  assign more      = ptr_r < cnt_r;
  assign hit_pos   = ptr_r - CW'(1);
  assign key_match = (rdata_r.first_char == item_r.first_char) &&
                     (rdata_r.second_char == item_r.second_char);

  // status towards the controller
  always_comb begin
    sts            = '0;
    sts.is_lookup  = item_r.kind == KIND_LOOKUP;
    sts.is_write   = item_r.kind == KIND_WRITE;
    sts.is_clear   = item_r.kind == KIND_CLEAR;
    sts.rsv        = (item_r.first_char == KEY_RESERVED) ||
                     (item_r.second_char == KEY_RESERVED);
    sts.off_zero   = item_r.offset_in == 8'sd0;
    sts.hit        = rd_vld_r && key_match;
    sts.miss       = !rd_vld_r && !more;
    sts.full       = cnt_r == CNT_MAX;
    sts.shift_done = !rd_vld_r;
  end

  // read port: one entry per cycle while scanning or shifting
  assign rd_en   = (cmd.scan || cmd.shift) && more;
  assign rd_addr = ptr_r[IW-1:0];

  // write port: offset update, append or move down by one place
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_pos[IW-1:0];
    wr_data = rdata_r;
    priority if (cmd.upd) begin
      wr_en   = 1'b1;
      wr_addr = hit_pos[IW-1:0];
      wr_data = '{first_char: item_r.first_char, second_char: item_r.second_char,
                  offset: item_r.offset_in};
    end else if (cmd.append) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r[IW-1:0];
      wr_data = '{first_char: item_r.first_char, second_char: item_r.second_char,
                  offset: item_r.offset_in};
    end else if (cmd.shift && rd_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = wp_r;
      wr_data = rdata_r;
    end else begin
      wr_en   = 1'b0;
    end
  end

  // pair store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // pointers and count
  always_comb begin
    ptr_nxt    = ptr_r;
    rd_vld_nxt = rd_vld_r;
    wp_nxt     = wp_r;
    cnt_nxt    = cnt_r;
    if (cmd.start) begin
      ptr_nxt    = '0;
      rd_vld_nxt = 1'b0;
    end
    if (cmd.scan || cmd.shift) begin
      rd_vld_nxt = more;
      if (more) begin
        ptr_nxt = ptr_r + CW'(1);
      end
    end
    if (cmd.hit) begin
      wp_nxt = hit_pos[IW-1:0];
    end else if (cmd.shift && rd_vld_r) begin
      wp_nxt = wp_r + IW'(1);
    end
    priority if (cmd.clear) begin
      cnt_nxt = '0;
    end else if (cmd.append) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // result fields gathered during the operation
  always_comb begin
    status_nxt = status_r;
    found_nxt  = found_r;
    old_nxt    = old_r;
    idx_nxt    = idx_r;
    if (cmd.start) begin
      status_nxt = STAT_OK;
      found_nxt  = 1'b0;
      old_nxt    = 8'sd0;
      idx_nxt    = '0;
    end
    if (cmd.reject) begin
      status_nxt = STAT_REJECT;
    end
    if (cmd.full) begin
      status_nxt = STAT_FULL;
    end
    if (cmd.hit) begin
      found_nxt = 1'b1;
      old_nxt   = rdata_r.offset;
      idx_nxt   = hit_pos[IW-1:0];
    end
    if (cmd.append) begin
      idx_nxt = cnt_r[IW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    wp_r     <= wp_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    old_r    <= old_nxt;
    idx_r    <= idx_nxt;
    if (cmd.start) begin
      item_r <= in_data;
    end
    if (cmd.load) begin
      out_r <= '{status: status_r, found: found_r, offset_out: old_r,
                 pair_index: 6'(idx_r), pair_count: 7'(cnt_r)};
    end
  end

  assign out_data = out_r;

  // count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("pair count beyond table depth");

  // append only into a free place
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> cnt_r < CNT_MAX)
    else $error("append into a full table");

  // a moved entry lands below the old count
  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && rd_vld_r) |-> (CW'(wp_r) + CW'(1)) < cnt_r)
    else $error("shift write outside the table");

  // held read data always belongs to an issued address
  a_rd_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ptr_r != '0)
    else $error("read data without an issued read");

endmodule

@@ rtl/kpt_ctrl.sv @@
module kpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output kpt_pkg::kpt_cmd_t cmd,
  input  kpt_pkg::kpt_sts_t sts
);
  import kpt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // output register may be refilled when empty or being taken
  assign out_free = !out_valid_r || !out_stall;

  // sequencing of one word
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.is_clear) begin
          cmd.clear = 1'b1;
          state_nxt = S_FINISH;
        end else if (sts.is_write && sts.rsv) begin
          cmd.reject = 1'b1;
          state_nxt  = S_FINISH;
        end else if (sts.is_lookup || sts.is_write) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        priority if (sts.hit) begin
          cmd.hit = 1'b1;
          if (sts.is_write && sts.off_zero) begin
            state_nxt = S_SHIFT;
          end else begin
            cmd.upd   = sts.is_write;
            state_nxt = S_FINISH;
          end
        end else if (sts.miss) begin
          if (sts.is_write && !sts.off_zero) begin
            cmd.full   = sts.full;
            cmd.append = !sts.full;
          end
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          cmd.dec   = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  // an accepted word is decoded next
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_DECODE)
    else $error("accepted word not decoded");

  // a finished result is presented and the block returns to idle
  a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented");

  // one user of the write port at a time
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.upd, cmd.append, cmd.shift}))
    else $error("write port conflict");

endmodule

@@ rtl/kerning_pair_table.sv @@
// kerning pair table: ordered store of character pairs, each with a signed
// spacing offset.
// input channel (in_valid, in_stall, in_data): one word per operation,
// lookup, write offset or clear. a word is taken when in_valid is high and
// in_stall is low; in_stall is low only while no word is in progress.
// result channel (out_valid, out_stall, out_data): exactly one result word per
// input word, in order. results sit in an output register, so the next input
// word is taken while a result still waits under out_stall.
// lookups and writes scan the held pairs in order until the pair is found or
// the last one is passed; a clear or a rejected write skips the scan. removing
// the pair at p moves every later entry down one place. the result shows in
// the same cycle that the next word can be taken. the pair memory has one
// read and one write port: the scan reads one entry a cycle with registered
// read data, and the move-down copies one entry a cycle.
// reset empties the table at once; no clearing pass is needed since only
// entries below the count are ever read. a stalled receiver holds the
// finished result and the block waits in its last step until it is taken.
module kerning_pair_table #(
  parameter int MAX_PAIRS = kpt_pkg::MAX_PAIRS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kpt_pkg::kpt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kpt_pkg::kpt_out_t out_data
);
  import kpt_pkg::*;

  kpt_cmd_t cmd;
  kpt_sts_t sts;

  // sequencer
  kpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // pair store, scan and result registers
  kpt_datapath #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ bench/kpt_checker.sv @@
module kpt_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  kpt_pkg::kpt_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  kpt_pkg::kpt_out_t out_data,
  output int                fault_count,
  output int                words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import kpt_pkg::*;

  // shadow copy of the pair table
  kpt_entry_t pair_table [MAX_PAIRS_DEF];
  int         pairs_held;

  // predicted result words, oldest first
  kpt_out_t   result_queue [$];

  // one line per fault
  task automatic report_fault(string what);
    $display("%0t kpt fault: %s", $time, what);
    fault_count++;
  endtask

  task automatic check_field(string field, int got, int want);
    if (got != want) begin
      report_fault($sformatf("%s got %0d want %0d", field, got, want));
    end
  endtask

  // position of the first matching pair, or pairs_held when absent
  function automatic int locate_pair(logic [7:0] a, logic [7:0] b);
    for (int k = 0; k < pairs_held; k++) begin
      if (pair_table[k].first_char == a && pair_table[k].second_char == b) begin
        return k;
      end
    end
    return pairs_held;
  endfunction

  // apply one operation to the shadow table and form its result word
  function automatic kpt_out_t apply_pair_op(kpt_in_t w);
    kpt_out_t r;
    int       pos;
    r   = '0;
    pos = locate_pair(w.first_char, w.second_char);
    case (w.kind)
      KIND_LOOKUP: begin
        if (pos < pairs_held) begin
          r.found      = 1'b1;
          r.offset_out = pair_table[pos].offset;
          r.pair_index = 6'(pos);
        end
      end
      KIND_WRITE: begin
        if (w.first_char == KEY_RESERVED || w.second_char == KEY_RESERVED) begin
          r.status = STAT_REJECT;
        end else if (pos < pairs_held) begin
          r.found      = 1'b1;
          r.offset_out = pair_table[pos].offset;
          r.pair_index = 6'(pos);
          if (w.offset_in != 0) begin
            pair_table[pos].offset = w.offset_in;
          end else begin
            // removal closes the gap: later entries move down one place
            for (int k = pos; k + 1 < pairs_held; k++) begin
              pair_table[k] = pair_table[k + 1];
            end
            pairs_held--;
          end
        end else if (w.offset_in != 0) begin
          if (pairs_held >= MAX_PAIRS_DEF) begin
            r.status = STAT_FULL;
          end else begin
            pair_table[pairs_held] = '{first_char: w.first_char,
                                       second_char: w.second_char,
                                       offset: w.offset_in};
            r.pair_index = 6'(pairs_held);
            pairs_held++;
          end
        end
      end
      KIND_CLEAR: begin
        pairs_held = 0;
      end
      default: ;
    endcase
    r.pair_count = 7'(pairs_held);
    return r;
  endfunction

  // watch both channels: results are checked before the new word is predicted
  always @(posedge clk) begin : watch
    kpt_out_t want;
    if (!rst_n) begin
      pairs_held = 0;
      result_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          report_fault($sformatf("result word %h with none expected", out_data));
        end else begin
          want = result_queue.pop_front();
          check_field("status", out_data.status, want.status);
          check_field("found", out_data.found, want.found);
          check_field("offset_out", out_data.offset_out, want.offset_out);
          check_field("pair_index", out_data.pair_index, want.pair_index);
          check_field("pair_count", out_data.pair_count, want.pair_count);
        end
      end
      if (in_valid && !in_stall) begin
        result_queue.push_back(apply_pair_op(in_data));
      end
    end
    words_pending = result_queue.size();
  end

endmodule

@@ bench/tb_kerning_pair_table.sv @@
module tb_kerning_pair_table;
  timeunit 1ns;
  timeprecision 1ps;
  import kpt_pkg::*;

  // the fourth operation code, which the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  kpt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  kpt_out_t out_data;

  int fault_count;
  int words_pending;

  // idling odds in percent and the long hold-off request
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_seq    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  // characters drawn often so that pairs repeat and hit
  logic [7:0] char_pool [6] = '{8'd0, 8'd1, 8'd65, 8'd127, 8'd128, 8'd254};

  // keys stored by a fill run
  logic [7:0] fill_first  [MAX_PAIRS_DEF];
  logic [7:0] fill_second [MAX_PAIRS_DEF];

  kerning_pair_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  kpt_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fault_count   (fault_count),
    .words_pending (words_pending)
  );

  always #5ns clk = ~clk;

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // offer one word after a random gap and wait until it is taken
  task automatic put_word(logic [1:0] k, logic [7:0] a, logic [7:0] b,
                          logic signed [7:0] off);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: k, first_char: a, second_char: b, offset_in: off};
    do @(posedge clk); while (in_stall);
  endtask

  // hold the sender back until every result has come
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 75) return char_pool[$urandom_range(5)];
    if (r < 80) return KEY_RESERVED;
    return 8'($urandom);
  endfunction

  function automatic logic signed [7:0] pick_offset();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'sd0;
    if (r < 33) return -8'sd128;
    if (r < 41) return 8'sd127;
    return 8'($urandom);
  endfunction

  // mostly lookups and writes on repeating pairs, with clears and noise
  task automatic run_mixed(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        put_word(KIND_LOOKUP, pick_char(), pick_char(), pick_offset());
      end else if (r < 88) begin
        put_word(KIND_WRITE, pick_char(), pick_char(), pick_offset());
      end else if (r < 91) begin
        put_word(KIND_CLEAR, pick_char(), pick_char(), pick_offset());
      end else if (r < 94) begin
        put_word(KIND_UNUSED, pick_char(), pick_char(), pick_offset());
      end else begin
        put_word(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // fill the table to capacity, push past it, then remove entries and append a new pair
  task automatic run_fill();
    int pick;
    put_word(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < MAX_PAIRS_DEF; i++) begin
      // distinct low six bits keep every key unique and never reserved
      fill_first[i]  = {2'($urandom_range(2)), 6'(i)};
      fill_second[i] = 8'($urandom_range(254));
      put_word(KIND_WRITE, fill_first[i], fill_second[i], 8'($urandom_range(1, 255)));
    end
    // appends of new keys to the full table
    for (int i = 0; i < 3; i++) begin
      put_word(KIND_WRITE, {2'b11, 6'($urandom_range(62))}, 8'($urandom),
               8'($urandom_range(1, 255)));
    end
    put_word(KIND_LOOKUP, fill_first[63], fill_second[63], 8'sd0);
    pick = $urandom_range(MAX_PAIRS_DEF - 1);
    put_word(KIND_WRITE, fill_first[pick], fill_second[pick], pick_offset());
    // remove the first entry, then a random one, then look behind them
    put_word(KIND_WRITE, fill_first[0], fill_second[0], 8'sd0);
    put_word(KIND_LOOKUP, fill_first[1], fill_second[1], 8'sd0);
    pick = $urandom_range(1, MAX_PAIRS_DEF - 1);
    put_word(KIND_WRITE, fill_first[pick], fill_second[pick], 8'sd0);
    put_word(KIND_LOOKUP, fill_first[63], fill_second[63], 8'sd0);
    put_word(KIND_WRITE, 8'd200, 8'd7, -8'sd5);
    put_word(KIND_LOOKUP, 8'd200, 8'd7, 8'sd0);
  endtask

  // stimulus and verdict
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 11;
    rx_idle_pct = 69;

    // directed words: special cases and field extremes
    put_word(KIND_LOOKUP, 8'd0, 8'd0, 8'sd0);
    put_word(KIND_WRITE, KEY_RESERVED, 8'd3, 8'sd9);
    put_word(KIND_WRITE, 8'd3, KEY_RESERVED, 8'sd9);
    put_word(KIND_WRITE, KEY_RESERVED, KEY_RESERVED, -8'sd1);
    put_word(KIND_WRITE, 8'd10, 8'd20, 8'sd0);
    put_word(KIND_WRITE, 8'd0, 8'd0, -8'sd128);
    put_word(KIND_WRITE, 8'd254, 8'd254, 8'sd127);
    put_word(KIND_WRITE, 8'd0, 8'd1, 8'sd1);
    put_word(KIND_WRITE, 8'd170, 8'd85, 8'sh55);
    put_word(KIND_LOOKUP, 8'd254, 8'd254, 8'sd0);
    put_word(KIND_WRITE, 8'd254, 8'd254, -8'sd1);
    put_word(KIND_LOOKUP, 8'd254, 8'd254, 8'sd0);
    put_word(KIND_LOOKUP, KEY_RESERVED, 8'd0, 8'sd0);
    put_word(KIND_LOOKUP, 8'd0, KEY_RESERVED, 8'sd0);
    put_word(KIND_WRITE, 8'd0, 8'd0, 8'sd0);
    put_word(KIND_LOOKUP, 8'd254, 8'd254, 8'sd0);
    put_word(KIND_LOOKUP, 8'd170, 8'd85, 8'sd0);
    put_word(KIND_UNUSED, 8'd254, 8'd254, 8'sd3);
    put_word(KIND_WRITE, 8'd170, 8'd85, 8'sd0);
    put_word(KIND_CLEAR, 8'hff, 8'hff, -8'sd1);
    put_word(KIND_LOOKUP, 8'd254, 8'd254, 8'sd0);
    put_word(KIND_WRITE, 8'd65, 8'd65, 8'sd12);

    // sender mostly busy, receiver mostly stalled
    run_fill();
    run_mixed(60);
    drain();

    // sender mostly idle, receiver mostly ready
    tx_idle_pct = 69;
    rx_idle_pct = 11;
    run_mixed(110);
    drain();

    // no idling: long receiver hold-off while words keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_mixed(40);
    hold_seq++;
    run_mixed(30);
    drain();
    run_fill();
    run_mixed(20);

    drain();
    repeat (150) @(posedge clk);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ kerning_pair_table.f @@
rtl/kpt_pkg.sv
rtl/kpt_datapath.sv
rtl/kpt_ctrl.sv
rtl/kerning_pair_table.sv
bench/kpt_checker.sv
bench/tb_kerning_pair_table.sv
